FILE: design/ansi_half_block_color_encoder_unit_defines.svh
// Assertion macros shared by the checking code of the half-block colour encoder.
// Depends on nothing; included by the checker file.
`ifndef ANSI_HALF_BLOCK_COLOR_ENCODER_UNIT_DEFINES_SVH
`define ANSI_HALF_BLOCK_COLOR_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HBCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hbce_pkg.sv
// Types, byte codes and helper functions of the half-block colour encoder.
// Depends on nothing; imported by every module of the block.
package hbce_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLUMNS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXEL_LINES = 1'b1;

    localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 11'd80;
    localparam logic [CFG_DATA_W-1:0] LINES_RESET   = 11'd48;

    localparam int QUEUE_DEPTH = 2;

    // Stream byte codes.
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BRK    = 8'h5B;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FORE   = 8'h33;
    localparam logic [7:0] CH_BACK   = 8'h34;
    localparam logic [7:0] CH_END_M  = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_GLYPH0 = 8'hE2;
    localparam logic [7:0] CH_GLYPH1 = 8'h96;
    localparam logic [7:0] CH_GLYPH2 = 8'h84;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Decimal digits of one channel: [0] ones, [1] tens, [2] hundreds.
    typedef logic [2:0][3:0] hbce_bcd_t;
    // Three channels: [0] red, [1] green, [2] blue.
    typedef hbce_bcd_t [2:0] hbce_rgb_t;

    // One classified pixel pair, as handed from the front to the back.
    typedef struct packed {
        logic      home;
        logic      fg_chg;
        logic      bg_chg;
        logic      newline;
        logic      frame_end;
        hbce_rgb_t fg;
        hbce_rgb_t bg;
    } hbce_job_t;

    typedef enum logic [4:0] {
        PH_HOME_ESC,
        PH_HOME_BRK,
        PH_HOME_H,
        PH_SGR_ESC,
        PH_SGR_BRK,
        PH_SEL,
        PH_EIGHT,
        PH_SEMI_A,
        PH_TWO,
        PH_SEMI_B,
        PH_DIGIT,
        PH_SEP,
        PH_JOIN,
        PH_END_M,
        PH_GLYPH0,
        PH_GLYPH1,
        PH_GLYPH2,
        PH_NEWLINE
    } hbce_phase_t;

    // Binary to three decimal digits; tens by multiply-by-reciprocal,
    // exact for remainders below 100.
    function automatic hbce_bcd_t to_bcd(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  o;
        hbce_bcd_t   res;
        if (v >= 8'd200)
        begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end
        else
        begin
            h = 2'd0;
            r = 7'(v);
        end
        prod = 15'(r) * 15'd205;
        t = 4'(prod >> 11);
        o = 7'(r - 7'(t) * 7'd10);
        res[2] = 4'(h);
        res[1] = t;
        res[0] = 4'(o);
        return res;
    endfunction

    // Index of the leading digit, leading zeros suppressed.
    function automatic logic [1:0] lead_digit(input hbce_bcd_t d);
        if (d[2] != 4'd0)
            return 2'd2;
        else if (d[1] != 4'd0)
            return 2'd1;
        else
            return 2'd0;
    endfunction

endpackage

FILE: design/ansi_half_block_color_encoder_unit.sv
// Top level of the ANSI truecolour half-block encoder.
// Depends on hbce_pkg, hbce_front, hbce_queue and hbce_back.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, top_*, bottom_*        | into block
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data  | into block
//  output  | out_valid/out_ready, out_byte, flags      | out of block
//
// Each pixel pair produces 3 to 43 bytes, one byte per cycle from the back-end
// sequencer while the output is not stalled; the sequencer moves from one pair
// straight on to the next queued pair.
// The front takes a new request whenever the two-entry queue has room, also while
// the output register holds a byte that has not been taken.
// Reset is asynchronous and active low; there is no clearing pass, the block
// accepts requests as soon as reset is released.
module ansi_half_block_color_encoder_unit #(
    parameter int MAX_COLUMNS     = 1024,
    parameter int MAX_PIXEL_LINES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hbce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbce_pkg::CFG_DATA_W-1:0] cfg_data,
    // Pixel pair channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     top_red,
    input  logic [7:0]                     top_green,
    input  logic [7:0]                     top_blue,
    input  logic [7:0]                     bottom_red,
    input  logic [7:0]                     bottom_green,
    input  logic [7:0]                     bottom_blue,
    // Byte stream channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           last_of_item,
    output logic                           frame_done
);
    import hbce_pkg::*;

    hbce_job_t new_job;
    hbce_job_t head_job;
    logic      accept;
    logic      q_full, q_empty, q_pop;

    // Configuration writes are always taken; the registers sit in the front.
    assign cfg_ready = 1'b1;

    // A request is taken whenever the queue has a free slot. The front updates
    // its colour memory and frame position in the same edge, so the next
    // request is classified against the already updated state.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    hbce_front #(
        .MAX_COLUMNS     (MAX_COLUMNS),
        .MAX_PIXEL_LINES (MAX_PIXEL_LINES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .top_red      (top_red),
        .top_green    (top_green),
        .top_blue     (top_blue),
        .bottom_red   (bottom_red),
        .bottom_green (bottom_green),
        .bottom_blue  (bottom_blue),
        .job          (new_job)
    );

    // The queue decouples classification from byte emission: the front stalls
    // only when two classified pairs already wait.
    hbce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_job (new_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_job)
    );

    // The back walks the head entry byte by byte and releases it with the
    // final byte of the pair (the glyph, or the newline ending a row mid-frame).
    hbce_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_empty),
        .head         (head_job),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .frame_done   (frame_done)
    );

endmodule

FILE: design/hbce_front.sv
// Front end of the half-block encoder: frame position, colour memory, classification.
// Depends on hbce_pkg.
module hbce_front #(
    parameter int MAX_COLUMNS     = 1024,
    parameter int MAX_PIXEL_LINES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [hbce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     top_red,
    input  logic [7:0]                     top_green,
    input  logic [7:0]                     top_blue,
    input  logic [7:0]                     bottom_red,
    input  logic [7:0]                     bottom_green,
    input  logic [7:0]                     bottom_blue,
    output hbce_pkg::hbce_job_t            job
);
    import hbce_pkg::*;

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_PIXEL_LINES > 2) ? $clog2((MAX_PIXEL_LINES + 1) / 2) : 1;
    localparam int CMP_W = $clog2(MAX_COLUMNS + MAX_PIXEL_LINES + 4096) + 1;

    logic [CFG_DATA_W-1:0] columns_reg;
    logic [CFG_DATA_W-1:0] lines_reg;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [7:0]            fore_r_reg, fore_g_reg, fore_b_reg;
    logic [7:0]            back_r_reg, back_g_reg, back_b_reg;
    logic                  fore_known_reg, back_known_reg;

    logic [CMP_W-1:0] cols_c, lines_c, twice_row;
    logic             home, black, fk, bk, fg_chg, bg_chg, row_end, last_row, frame_end;
    logic [7:0]       br, bgr, bb;

    always_comb
    begin
        if (columns_reg == '0)
            cols_c = CMP_W'(1);
        else if (CMP_W'(columns_reg) > CMP_W'(MAX_COLUMNS))
            cols_c = CMP_W'(MAX_COLUMNS);
        else
            cols_c = CMP_W'(columns_reg);

        if (lines_reg == '0)
            lines_c = CMP_W'(1);
        else if (CMP_W'(lines_reg) > CMP_W'(MAX_PIXEL_LINES))
            lines_c = CMP_W'(MAX_PIXEL_LINES);
        else
            lines_c = CMP_W'(lines_reg);

        home      = (col_reg == '0) && (row_reg == '0);
        fk        = fore_known_reg && !home;
        bk        = back_known_reg && !home;
        twice_row = CMP_W'(row_reg) << 1;
        // Lower pixel of the last text row does not exist on an odd height.
        black     = (twice_row + CMP_W'(1)) >= lines_c;
        last_row  = (twice_row + CMP_W'(2)) >= lines_c;
        row_end   = (CMP_W'(col_reg) + CMP_W'(1)) >= cols_c;
        frame_end = row_end && last_row;

        br  = black ? 8'd0 : bottom_red;
        bgr = black ? 8'd0 : bottom_green;
        bb  = black ? 8'd0 : bottom_blue;

        fg_chg = !fk || (br != fore_r_reg) || (bgr != fore_g_reg) || (bb != fore_b_reg);
        bg_chg = !bk || (top_red != back_r_reg) || (top_green != back_g_reg)
                 || (top_blue != back_b_reg);

        job.home      = home;
        job.fg_chg    = fg_chg;
        job.bg_chg    = bg_chg;
        job.newline   = row_end && !frame_end;
        job.frame_end = frame_end;
        job.fg[0]     = to_bcd(br);
        job.fg[1]     = to_bcd(bgr);
        job.fg[2]     = to_bcd(bb);
        job.bg[0]     = to_bcd(top_red);
        job.bg[1]     = to_bcd(top_green);
        job.bg[2]     = to_bcd(top_blue);

        if (frame_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= COLUMNS_RESET;
            lines_reg      <= LINES_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            fore_known_reg <= 1'b0;
            back_known_reg <= 1'b0;
            fore_r_reg     <= '0;
            fore_g_reg     <= '0;
            fore_b_reg     <= '0;
            back_r_reg     <= '0;
            back_g_reg     <= '0;
            back_b_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_FRAME_COLUMNS)
                    columns_reg <= cfg_data;
                else if (cfg_index == CFG_FRAME_PIXEL_LINES)
                    lines_reg <= cfg_data;
            end
            if (accept)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                fore_known_reg <= fk || fg_chg;
                back_known_reg <= bk || bg_chg;
                if (fg_chg)
                begin
                    fore_r_reg <= br;
                    fore_g_reg <= bgr;
                    fore_b_reg <= bb;
                end
                if (bg_chg)
                begin
                    back_r_reg <= top_red;
                    back_g_reg <= top_green;
                    back_b_reg <= top_blue;
                end
            end
        end
    end

endmodule

FILE: design/hbce_queue.sv
// Short queue of classified pixel pairs between the front and the back.
// Depends on hbce_pkg.
module hbce_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hbce_pkg::hbce_job_t push_job,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output hbce_pkg::hbce_job_t head
);
    import hbce_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hbce_job_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: design/hbce_back.sv
// Back end of the half-block encoder: byte sequencer and output register.
// Depends on hbce_pkg.
module hbce_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  hbce_pkg::hbce_job_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_item,
    output logic                frame_done
);
    import hbce_pkg::*;

    hbce_phase_t phase_reg, phase_next, cur;
    logic        start_reg;
    logic        sel_reg, sel_next;
    logic [1:0]  comp_reg, comp_next;
    logic [1:0]  dig_reg, dig_next;
    logic        item_end;
    logic        load;
    logic [7:0]  byte_val;
    hbce_bcd_t   chan;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg, done_reg;

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && item_end;
    assign chan = sel_reg ? head.bg[comp_reg] : head.fg[comp_reg];

    // Phase of the byte emitted now; a fresh item chooses its own first phase.
    always_comb
    begin
        if (!start_reg)
            cur = phase_reg;
        else if (head.home)
            cur = PH_HOME_ESC;
        else if (head.fg_chg || head.bg_chg)
            cur = PH_SGR_ESC;
        else
            cur = PH_GLYPH0;
    end

    // Next-state logic.
    always_comb
    begin
        phase_next = cur;
        sel_next   = sel_reg;
        comp_next  = comp_reg;
        dig_next   = dig_reg;
        item_end   = 1'b0;
        case (cur)
            PH_HOME_ESC: phase_next = PH_HOME_BRK;
            PH_HOME_BRK: phase_next = PH_HOME_H;
            PH_HOME_H:   phase_next = (head.fg_chg || head.bg_chg) ? PH_SGR_ESC : PH_GLYPH0;
            PH_SGR_ESC:  phase_next = PH_SGR_BRK;
            PH_SGR_BRK:
            begin
                phase_next = PH_SEL;
                sel_next   = !head.fg_chg;
            end
            PH_SEL:      phase_next = PH_EIGHT;
            PH_EIGHT:    phase_next = PH_SEMI_A;
            PH_SEMI_A:   phase_next = PH_TWO;
            PH_TWO:      phase_next = PH_SEMI_B;
            PH_SEMI_B:
            begin
                phase_next = PH_DIGIT;
                comp_next  = 2'd0;
                dig_next   = lead_digit(sel_reg ? head.bg[0] : head.fg[0]);
            end
            PH_DIGIT:
            begin
                if (dig_reg != 2'd0)
                    dig_next = dig_reg - 2'd1;
                else if (comp_reg != 2'd2)
                    phase_next = PH_SEP;
                else if (!sel_reg && head.bg_chg)
                    phase_next = PH_JOIN;
                else
                    phase_next = PH_END_M;
            end
            PH_SEP:
            begin
                phase_next = PH_DIGIT;
                comp_next  = comp_reg + 2'd1;
                dig_next   = lead_digit(sel_reg ? head.bg[comp_reg + 2'd1]
                                                : head.fg[comp_reg + 2'd1]);
            end
            PH_JOIN:
            begin
                phase_next = PH_SEL;
                sel_next   = 1'b1;
            end
            PH_END_M:    phase_next = PH_GLYPH0;
            PH_GLYPH0:   phase_next = PH_GLYPH1;
            PH_GLYPH1:   phase_next = PH_GLYPH2;
            PH_GLYPH2:
            begin
                phase_next = PH_NEWLINE;
                item_end   = !head.newline;
            end
            PH_NEWLINE:  item_end = 1'b1;
            default:     item_end = 1'b1;
        endcase
    end

    // Output byte of the current phase.
    always_comb
    begin
        case (cur)
            PH_HOME_ESC: byte_val = CH_ESC;
            PH_HOME_BRK: byte_val = CH_BRK;
            PH_HOME_H:   byte_val = CH_HOME;
            PH_SGR_ESC:  byte_val = CH_ESC;
            PH_SGR_BRK:  byte_val = CH_BRK;
            PH_SEL:      byte_val = sel_reg ? CH_BACK : CH_FORE;
            PH_EIGHT:    byte_val = CH_EIGHT;
            PH_SEMI_A:   byte_val = CH_SEMI;
            PH_TWO:      byte_val = CH_TWO;
            PH_SEMI_B:   byte_val = CH_SEMI;
            PH_DIGIT:    byte_val = CH_ZERO + 8'(chan[dig_reg]);
            PH_SEP:      byte_val = CH_SEMI;
            PH_JOIN:     byte_val = CH_SEMI;
            PH_END_M:    byte_val = CH_END_M;
            PH_GLYPH0:   byte_val = CH_GLYPH0;
            PH_GLYPH1:   byte_val = CH_GLYPH1;
            PH_GLYPH2:   byte_val = CH_GLYPH2;
            PH_NEWLINE:  byte_val = CH_NL;
            default:     byte_val = CH_NL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_GLYPH0;
            start_reg     <= 1'b1;
            sel_reg       <= 1'b0;
            comp_reg      <= '0;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_next;
                start_reg <= item_end;
                sel_reg   <= sel_next;
                comp_reg  <= comp_next;
                dig_reg   <= dig_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_val;
            last_reg     <= item_end;
            done_reg     <= item_end && head.frame_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = last_reg;
    assign frame_done   = done_reg;

endmodule

FILE: design/hbce_checker.sv
// Port-level checks of the half-block encoder output stream, bound to the top level.
// Depends on hbce_pkg and ansi_half_block_color_encoder_unit_defines.svh.
`include "ansi_half_block_color_encoder_unit_defines.svh"

module hbce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_item,
    input logic       frame_done
);
    import hbce_pkg::*;

    logic expect_home_reg;

    // After reset and after each frame the next byte must open a cursor-home.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expect_home_reg <= 1'b1;
        else if (out_valid && out_ready)
            expect_home_reg <= frame_done;
    end

    `HBCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last_of_item), "output byte changed while stalled")
    `HBCE_ASSERT_IMPLY(a_done_last, clk, rst_n, out_valid && frame_done, last_of_item, "frame end not on the last byte of a pair")
    `HBCE_ASSERT_IMPLY(a_last_byte, clk, rst_n, out_valid && last_of_item, out_byte == CH_GLYPH2 || out_byte == CH_NL, "pair does not end in glyph or newline")
    `HBCE_ASSERT_IMPLY(a_frame_home, clk, rst_n, out_valid && expect_home_reg, out_byte == CH_ESC, "frame does not open with cursor-home")

endmodule

bind ansi_half_block_color_encoder_unit hbce_checker u_hbce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_of_item (last_of_item),
    .frame_done   (frame_done)
);

FILE: sim/tb_top.sv
// Self-checking testbench of the ANSI truecolour half-block encoder.
// Depends on hbce_pkg and ansi_half_block_color_encoder_unit; needs nothing else.
`timescale 1ns / 1ps

module tb_top;

    import hbce_pkg::*;

    localparam int LIMIT_COLUMNS = 1024;
    localparam int LIMIT_LINES   = 1024;
    localparam int RANDOM_ITEMS  = 300;

    // One byte of the terminal stream together with its two flags.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } stream_byte_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            top_red;
    logic [7:0]            top_green;
    logic [7:0]            top_blue;
    logic [7:0]            bottom_red;
    logic [7:0]            bottom_green;
    logic [7:0]            bottom_blue;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    logic                  last_of_item;
    logic                  frame_done;

    ansi_half_block_color_encoder_unit #(
        .MAX_COLUMNS     (LIMIT_COLUMNS),
        .MAX_PIXEL_LINES (LIMIT_LINES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .top_red      (top_red),
        .top_green    (top_green),
        .top_blue     (top_blue),
        .bottom_red   (bottom_red),
        .bottom_green (bottom_green),
        .bottom_blue  (bottom_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .frame_done   (frame_done)
    );

    // Shadow copy of the block: register contents as written, the colours the
    // terminal is believed to hold, and the position within the frame.
    logic [CFG_DATA_W-1:0] shadow_columns;
    logic [CFG_DATA_W-1:0] shadow_lines;
    logic [7:0]            fg_red, fg_green, fg_blue;
    logic                  fg_known;
    logic [7:0]            bg_red, bg_green, bg_blue;
    logic                  bg_known;
    logic [10:0]           column_pos;
    logic [10:0]           row_pos;

    // Bytes that one pixel pair is due to produce, gathered before queueing.
    logic [7:0]   pair_bytes [0:63];
    int           pair_len;
    stream_byte_t stream_bytes_due [$];

    // Colours that random pairs mostly draw from, so that repeats (and with
    // them pairs that need no colour sequence) happen often.
    logic [7:0] palette_red   [0:3];
    logic [7:0] palette_green [0:3];
    logic [7:0] palette_blue  [0:3];

    // When set, the corresponding side neither waits between requests nor stalls.
    bit calm_sender;
    bit calm_receiver;

    int errors;
    int pairs_sent;
    int bytes_checked;
    int frames_seen;
    int reg_writes;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A generous ceiling: every pair at its longest with the longest stall on
    // every byte still finishes well inside this.
    initial
    begin
        #3_000_000;
        $display("[ansi_half_block_color_encoder_unit] ERROR");
        $finish;
    end

    function automatic int effective_size(input logic [CFG_DATA_W-1:0] raw, input int hi);
        if (raw == '0)
            return 1;
        if (int'(raw) > hi)
            return hi;
        return int'(raw);
    endfunction

    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        pair_bytes[pair_len] = b;
        pair_len++;
    endtask

    // Decimal text of a channel value, leading zeros dropped.
    task automatic add_decimal(input logic [7:0] v);
        if (v >= 8'd100)
            add_byte(CH_ZERO + 8'(v / 8'd100));
        if (v >= 8'd10)
            add_byte(CH_ZERO + 8'((v / 8'd10) % 8'd10));
        add_byte(CH_ZERO + 8'(v % 8'd10));
    endtask

    // "38;2;R;G;B" or "48;2;R;G;B", depending on the selector digit.
    task automatic add_colour(input logic [7:0] sel, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
        add_byte(sel);
        add_byte(CH_EIGHT);
        add_byte(CH_SEMI);
        add_byte(CH_TWO);
        add_byte(CH_SEMI);
        add_decimal(r);
        add_byte(CH_SEMI);
        add_decimal(g);
        add_byte(CH_SEMI);
        add_decimal(b);
    endtask

    // Works out the bytes that one accepted pixel pair produces and queues them.
    task automatic predict_pair_bytes(input logic [7:0] tr, input logic [7:0] tg,
                                      input logic [7:0] tb, input logic [7:0] br,
                                      input logic [7:0] bgr, input logic [7:0] bb);
        int           cols;
        int           lines;
        int           rows;
        logic [7:0]   lr, lg, lb;
        logic         fg_change;
        logic         bg_change;
        logic         row_end;
        logic         frame_end;
        stream_byte_t entry;
        cols  = effective_size(shadow_columns, LIMIT_COLUMNS);
        lines = effective_size(shadow_lines, LIMIT_LINES);
        rows  = (lines + 1) / 2;
        lr = br;
        lg = bgr;
        lb = bb;
        pair_len = 0;

        // The first pair of a frame homes the cursor and forgets both colours.
        if (column_pos == '0 && row_pos == '0)
        begin
            add_byte(CH_ESC);
            add_byte(CH_BRK);
            add_byte(CH_HOME);
            fg_known = 1'b0;
            bg_known = 1'b0;
        end

        // In the last text row of an odd-height frame the lower pixel is black.
        if (2 * int'(row_pos) + 1 >= lines)
        begin
            lr = 8'd0;
            lg = 8'd0;
            lb = 8'd0;
        end

        fg_change = !fg_known || lr != fg_red || lg != fg_green || lb != fg_blue;
        bg_change = !bg_known || tr != bg_red || tg != bg_green || tb != bg_blue;

        if (fg_change || bg_change)
        begin
            add_byte(CH_ESC);
            add_byte(CH_BRK);
            if (fg_change)
                add_colour(CH_FORE, lr, lg, lb);
            if (fg_change && bg_change)
                add_byte(CH_SEMI);
            if (bg_change)
                add_colour(CH_BACK, tr, tg, tb);
            add_byte(CH_END_M);
        end
        if (fg_change)
        begin
            fg_red   = lr;
            fg_green = lg;
            fg_blue  = lb;
            fg_known = 1'b1;
        end
        if (bg_change)
        begin
            bg_red   = tr;
            bg_green = tg;
            bg_blue  = tb;
            bg_known = 1'b1;
        end

        add_byte(CH_GLYPH0);
        add_byte(CH_GLYPH1);
        add_byte(CH_GLYPH2);

        // A position already past a bound that was lowered ends on this pair.
        row_end   = int'(column_pos) + 1 >= cols;
        frame_end = row_end && int'(row_pos) + 1 >= rows;
        if (row_end && !frame_end)
            add_byte(CH_NL);

        if (frame_end)
        begin
            column_pos = '0;
            row_pos    = '0;
        end
        else if (row_end)
        begin
            column_pos = '0;
            row_pos    = row_pos + 11'd1;
        end
        else
            column_pos = column_pos + 11'd1;

        for (int k = 0; k < pair_len; k++)
        begin
            entry.data = pair_bytes[k];
            entry.last = (k == pair_len - 1);
            entry.done = frame_end && (k == pair_len - 1);
            stream_bytes_due.push_back(entry);
        end
    endtask

    // Offers one pixel pair after a drawn pause and holds it until the request
    // is taken. The caller always resumes just after a rising edge, and valid
    // is only lowered when a pause is drawn, so it never drops between
    // back-to-back requests.
    task automatic send_pair(input logic [7:0] tr, input logic [7:0] tg,
                             input logic [7:0] tb, input logic [7:0] br,
                             input logic [7:0] bgr, input logic [7:0] bb);
        int gap;
        gap = draw_wait(calm_sender);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        top_red      <= tr;
        top_green    <= tg;
        top_blue     <= tb;
        bottom_red   <= br;
        bottom_green <= bgr;
        bottom_blue  <= bb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pair_bytes(tr, tg, tb, br, bgr, bb);
        pairs_sent++;
    endtask

    // Withdraws the pixel channel and waits until every byte due has arrived.
    task automatic drain_stream;
        in_valid <= 1'b0;
        @(posedge clk);
        while (stream_bytes_due.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only ever issued once the stream has drained. Valid is
    // dropped afterwards so that consecutive writes stay apart.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == CFG_FRAME_COLUMNS)
            shadow_columns = value;
        else
            shadow_lines = value;
        reg_writes++;
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] cols,
                             input logic [CFG_DATA_W-1:0] lines);
        drain_stream();
        write_register(CFG_FRAME_COLUMNS, cols);
        write_register(CFG_FRAME_PIXEL_LINES, lines);
    endtask

    task automatic pick_colour(output logic [7:0] r, output logic [7:0] g,
                               output logic [7:0] b);
        int slot;
        if ($urandom_range(0, 9) < 7)
        begin
            slot = $urandom_range(0, 3);
            r = palette_red[slot];
            g = palette_green[slot];
            b = palette_blue[slot];
        end
        else
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
    endtask

    task automatic send_random_pair;
        logic [7:0] tr, tg, tb, br, bgr, bb;
        pick_colour(tr, tg, tb);
        pick_colour(br, bgr, bb);
        send_pair(tr, tg, tb, br, bgr, bb);
    endtask

    // Reset sizes of 80 by 48: every kind of colour sequence, and the pair
    // that needs none because both colours repeat.
    task automatic test_sequence_kinds;
        send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_pair(8'd0, 8'd0, 8'd0, 8'd9, 8'd10, 8'd99);
        send_pair(8'd100, 8'd200, 8'd255, 8'd9, 8'd10, 8'd99);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        send_random_pair();
    endtask

    // Register values of zero act as one, so every pair is a whole frame; then
    // an even one-column frame and a small odd frame with its black last row.
    task automatic test_small_frames;
        set_frame(11'd0, 11'd0);
        repeat (3) send_random_pair();
        set_frame(11'd1, 11'd2);
        repeat (2) send_random_pair();
        set_frame(11'd3, 11'd3);
        repeat (7) send_random_pair();
    endtask

    // Sizes above the maximum act as the maximum; then the bounds are lowered
    // part-way through a frame so that a position already past them ends at
    // once.
    task automatic test_size_bounds;
        set_frame(11'd2047, 11'd2047);
        repeat (2) send_random_pair();
        set_frame(11'd1024, 11'd1024);
        repeat (4) send_random_pair();
        drain_stream();
        write_register(CFG_FRAME_COLUMNS, 11'd2);
        send_random_pair();
        drain_stream();
        write_register(CFG_FRAME_PIXEL_LINES, 11'd1);
        repeat (2) send_random_pair();
    endtask

    // Phases of random pairs: mostly small frames so that frame ends, odd rows
    // and new frames come often, with now and then an extreme size. Phases
    // rarely end on a frame boundary, so register writes also land mid-frame.
    task automatic test_random_frames;
        int         count;
        int         pick;
        logic [10:0] cols;
        logic [10:0] lines;
        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cols = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'($urandom_range(0, 2047));
            else
                cols = 11'($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                lines = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1024, 2047));
            else
                lines = 11'($urandom_range(1, 7));
            drain_stream();
            if ($urandom_range(0, 4) != 0)
                write_register(CFG_FRAME_COLUMNS, cols);
            if ($urandom_range(0, 4) != 0)
                write_register(CFG_FRAME_PIXEL_LINES, lines);
            for (int k = 0; k < 4; k++)
            begin
                palette_red[k]   = 8'($urandom);
                palette_green[k] = 8'($urandom);
                palette_blue[k]  = 8'($urandom);
            end
            calm_sender   = ($urandom_range(0, 3) == 0);
            calm_receiver = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(5, 30);
            repeat (pick) send_random_pair();
            count += pick;
        end
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
    endtask

    // Byte sink: stalls for a drawn number of cycles before each byte, then
    // holds ready until the byte is taken.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(calm_receiver);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Every byte taken from the block is compared with the oldest one due.
    always @(posedge clk)
    begin
        stream_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (frame_done)
                frames_seen++;
            if (stream_bytes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected byte %02h (last %b, done %b) with nothing due",
                             out_byte, last_of_item, frame_done);
            end
            else
            begin
                want = stream_bytes_due.pop_front();
                if (out_byte !== want.data || last_of_item !== want.last ||
                    frame_done !== want.done)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("byte %0d: expected %02h last %b done %b, got %02h last %b done %b",
                                 bytes_checked, want.data, want.last, want.done,
                                 out_byte, last_of_item, frame_done);
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_FRAME_COLUMNS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        top_red      = '0;
        top_green    = '0;
        top_blue     = '0;
        bottom_red   = '0;
        bottom_green = '0;
        bottom_blue  = '0;

        shadow_columns = COLUMNS_RESET;
        shadow_lines   = LINES_RESET;
        fg_red = '0; fg_green = '0; fg_blue = '0; fg_known = 1'b0;
        bg_red = '0; bg_green = '0; bg_blue = '0; bg_known = 1'b0;
        column_pos = '0;
        row_pos    = '0;
        for (int k = 0; k < 4; k++)
        begin
            palette_red[k]   = 8'($urandom);
            palette_green[k] = 8'($urandom);
            palette_blue[k]  = 8'($urandom);
        end
        calm_sender   = 1'b0;
        calm_receiver = 1'b0;
        errors        = 0;
        pairs_sent    = 0;
        bytes_checked = 0;
        frames_seen   = 0;
        reg_writes    = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sequence_kinds();
        test_small_frames();
        test_size_bounds();
        test_random_frames();

        // Let the stream run dry, then watch a little longer for stray bytes.
        drain_stream();
        repeat (32) @(posedge clk);
        if (stream_bytes_due.size() != 0)
            errors++;

        $display("covered %0d pixel pairs, %0d stream bytes, %0d completed frames",
                 pairs_sent, bytes_checked, frames_seen);
        $display("across %0d register writes; %0d failures", reg_writes, errors);
        if (errors == 0)
            $display("[ansi_half_block_color_encoder_unit] OK");
        else
            $display("[ansi_half_block_color_encoder_unit] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/hbce_pkg.sv
design/hbce_front.sv
design/hbce_queue.sv
design/hbce_back.sv
design/ansi_half_block_color_encoder_unit.sv
design/hbce_checker.sv
sim/tb_top.sv
